FILE: rtl/epo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package epo_pkg;

  localparam int PHASE_BITS = 32;

  localparam int CV_W       = 17;
  localparam int WAVE_W     = 16;
  localparam int KNOB_W     = 13;
  localparam int STEP_W     = 29;
  localparam int CFG_DATA_W = 29;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_PITCH_KNOB = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_C4_STEP    = 1'b1;

  localparam logic [STEP_W-1:0] C4_STEP_RESET = 29'd25480000;

  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  localparam int PITCH_LIMIT = 16384;
  localparam int WAVE_FULL   = 20480;

  // product shift for the phase increment is INC_SHIFT_BASE - octave code
  localparam int INC_SHIFT_BASE = 66 - PHASE_BITS;

  localparam int PROD_W = 66;
  localparam int MA_W   = 34;
  localparam int MB_W   = 32;
  localparam int DIV_W  = 36;
  localparam int DIV_STEPS = 9;

  localparam logic [4:0] MANT_TERMS  = 5'd10;
  localparam logic [4:0] PHASE_TERMS = 5'd16;
  localparam logic [4:0] COS_TERMS   = 5'd10;

  localparam logic [2:0] MUL_X    = 3'd0;
  localparam logic [2:0] MUL_TERM = 3'd1;
  localparam logic [2:0] MUL_INC  = 3'd2;
  localparam logic [2:0] MUL_PH   = 3'd3;
  localparam logic [2:0] MUL_SQ   = 3'd4;

  localparam logic ARG_SHR12 = 1'b0;
  localparam logic ARG_SHR30 = 1'b1;

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       arg_ld;
    logic       arg_src;
    logic       series_init;
    logic       div_start;
    logic       div_step;
    logic       term_acc;
    logic       term_sub;
    logic       series_cos;
    logic [4:0] k;
    logic       phase_ld;
    logic       ad_ld;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

  function automatic logic [8:0] series_divisor(input logic is_cos, input logic [4:0] k);
    logic [8:0] d;
    d = {4'b0, k};
    if (is_cos) begin
      case (k)
        5'd1:    d = 9'd2;
        5'd2:    d = 9'd12;
        5'd3:    d = 9'd30;
        5'd4:    d = 9'd56;
        5'd5:    d = 9'd90;
        5'd6:    d = 9'd132;
        5'd7:    d = 9'd182;
        5'd8:    d = 9'd240;
        5'd9:    d = 9'd306;
        5'd10:   d = 9'd380;
        default: d = 9'd1;
      endcase
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/epo_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module epo_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [epo_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [epo_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [epo_pkg::CV_W-1:0]       pitch_cv,
  input  epo_pkg::cmd_t                         cmd,
  output epo_pkg::sts_t                         sts,
  output logic signed [epo_pkg::WAVE_W-1:0]     wave_sample
);

  logic [epo_pkg::KNOB_W-1:0]     pitch_knob;
  logic [epo_pkg::STEP_W-1:0]     c4_phase_step;
  logic [epo_pkg::PHASE_BITS-1:0] phase;
  logic [15:0]                    q;
  logic [epo_pkg::MA_W-1:0]       arg;
  logic [31:0]                    term;
  logic signed [35:0]             sum;
  logic [epo_pkg::PROD_W-1:0]     prod;
  logic [epo_pkg::DIV_W-1:0]      dq;
  logic [8:0]                     rem;
  logic [3:0]                     div_cnt;
  logic [31:0]                    ad;

  logic signed [17:0]             pitch_sum;
  logic [15:0]                    q_in;
  logic [epo_pkg::MA_W-1:0]       mul_a;
  logic [epo_pkg::MB_W-1:0]       mul_b;
  logic [epo_pkg::PHASE_BITS+29:0] ph_ext;
  logic [29:0]                    tq;
  logic [6:0]                     shamt;
  logic [epo_pkg::PROD_W-1:0]     inc_full;
  logic [8:0]                     divisor;
  logic [8:0]                     r_w;
  logic [9:0]                     t_w;
  logic [epo_pkg::DIV_W-1:0]      d_w;
  logic signed [35:0]             cos_arg;
  logic signed [35:0]             neg_sum;
  logic signed [35:0]             s_cl;
  logic [31:0]                    w;
  logic [34:0]                    w5;
  logic [16:0]                    u;
  logic [15:0]                    u_cl;

  always_comb begin
    pitch_sum = $signed({5'b0, pitch_knob}) + $signed({pitch_cv[16], pitch_cv});
    if (pitch_sum > epo_pkg::PITCH_LIMIT) begin
      q_in = 16'(2 * epo_pkg::PITCH_LIMIT);
    end else if (pitch_sum < -epo_pkg::PITCH_LIMIT) begin
      q_in = '0;
    end else begin
      q_in = 16'(pitch_sum + epo_pkg::PITCH_LIMIT);
    end
  end

  assign ph_ext = {phase, 30'b0};
  assign tq     = ph_ext[epo_pkg::PHASE_BITS+29 -: 30];

  always_comb begin
    case (cmd.mul_sel)
      epo_pkg::MUL_X: begin
        mul_a = {22'b0, q[11:0]};
        mul_b = {2'b0, epo_pkg::LN2_Q30};
      end
      epo_pkg::MUL_TERM: begin
        mul_a = arg;
        mul_b = term;
      end
      epo_pkg::MUL_INC: begin
        mul_a = {5'b0, c4_phase_step};
        mul_b = sum[31:0];
      end
      epo_pkg::MUL_PH: begin
        mul_a = {4'b0, tq};
        mul_b = {1'b0, epo_pkg::HALF_PI_Q30};
      end
      epo_pkg::MUL_SQ: begin
        mul_a = {2'b0, ad};
        mul_b = ad;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign shamt    = 7'(epo_pkg::INC_SHIFT_BASE) - {3'b0, q[15:12]};
  assign inc_full = prod >> shamt;

  assign divisor = epo_pkg::series_divisor(cmd.series_cos, cmd.k);

  // radix-16 restoring division: four quotient bits per cycle
  always_comb begin
    r_w = rem;
    d_w = dq;
    t_w = '0;
    for (int i = 0; i < 4; i++) begin
      t_w = {r_w, d_w[epo_pkg::DIV_W-1]};
      d_w = {d_w[epo_pkg::DIV_W-2:0], 1'b0};
      if (t_w >= {1'b0, divisor}) begin
        t_w    = t_w - {1'b0, divisor};
        d_w[0] = 1'b1;
      end
      r_w = t_w[8:0];
    end
  end

  assign sts.div_last = (div_cnt == 4'(epo_pkg::DIV_STEPS - 1));

  assign cos_arg = sum - $signed({4'b0, epo_pkg::PI_Q30});

  always_comb begin
    neg_sum = -sum;
    if (neg_sum < -$signed({5'b0, epo_pkg::ONE_Q30})) begin
      s_cl = -$signed({5'b0, epo_pkg::ONE_Q30});
    end else if (neg_sum > $signed({5'b0, epo_pkg::ONE_Q30})) begin
      s_cl = $signed({5'b0, epo_pkg::ONE_Q30});
    end else begin
      s_cl = neg_sum;
    end
    w  = 32'(s_cl + $signed({5'b0, epo_pkg::ONE_Q30}));
    w5 = {1'b0, w, 2'b0} + {3'b0, w};
    u  = 17'((w5 + 35'h2_0000) >> 18);
    if (u > 17'(2 * epo_pkg::WAVE_FULL)) begin
      u_cl = 16'(2 * epo_pkg::WAVE_FULL);
    end else begin
      u_cl = u[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_knob    <= '0;
      c4_phase_step <= epo_pkg::C4_STEP_RESET;
      phase         <= '0;
      div_cnt       <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          epo_pkg::REG_PITCH_KNOB: pitch_knob    <= cfg_data[epo_pkg::KNOB_W-1:0];
          epo_pkg::REG_C4_STEP:    c4_phase_step <= cfg_data[epo_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.phase_ld) begin
        phase <= phase + inc_full[epo_pkg::PHASE_BITS-1:0];
      end
      if (cmd.div_start) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      q <= q_in;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.arg_ld) begin
      if (cmd.arg_src == epo_pkg::ARG_SHR12) begin
        arg <= {4'b0, prod[41:12]};
      end else begin
        arg <= prod[63:30];
      end
    end
    if (cmd.div_start) begin
      dq  <= prod[65:30];
      rem <= '0;
    end else if (cmd.div_step) begin
      dq  <= d_w;
      rem <= r_w;
    end
    if (cmd.series_init) begin
      term <= 32'(epo_pkg::ONE_Q30);
      sum  <= $signed({5'b0, epo_pkg::ONE_Q30});
    end else if (cmd.term_acc) begin
      term <= dq[31:0];
      if (cmd.term_sub) begin
        sum <= sum - $signed(dq);
      end else begin
        sum <= sum + $signed(dq);
      end
    end
    if (cmd.ad_ld) begin
      ad <= cos_arg[35] ? 32'(-cos_arg) : cos_arg[31:0];
    end
    if (cmd.out_ld) begin
      wave_sample <= $signed(u_cl - 16'(epo_pkg::WAVE_FULL));
    end
  end

endmodule

`default_nettype wire

FILE: rtl/epo_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module epo_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  epo_pkg::sts_t sts,
  output epo_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_X_MUL   = 4'd1;
  localparam logic [3:0] S_LD_X    = 4'd2;
  localparam logic [3:0] S_SER_MUL = 4'd3;
  localparam logic [3:0] S_SER_DLD = 4'd4;
  localparam logic [3:0] S_SER_DIV = 4'd5;
  localparam logic [3:0] S_SER_ACC = 4'd6;
  localparam logic [3:0] S_INC_MUL = 4'd7;
  localparam logic [3:0] S_INC_ADD = 4'd8;
  localparam logic [3:0] S_PH_MUL  = 4'd9;
  localparam logic [3:0] S_LD_A    = 4'd10;
  localparam logic [3:0] S_LD_D    = 4'd11;
  localparam logic [3:0] S_SQ_MUL  = 4'd12;
  localparam logic [3:0] S_LD_D2   = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  localparam logic [1:0] STG_MANT  = 2'd0;
  localparam logic [1:0] STG_PHASE = 2'd1;
  localparam logic [1:0] STG_COS   = 2'd2;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [4:0] k;
  logic [4:0] k_next;
  logic [1:0] stage;
  logic [1:0] stage_next;
  logic [4:0] n_terms;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    case (stage)
      STG_MANT:  n_terms = epo_pkg::MANT_TERMS;
      STG_PHASE: n_terms = epo_pkg::PHASE_TERMS;
      default:   n_terms = epo_pkg::COS_TERMS;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.k          = k;
    cmd.series_cos = (stage == STG_COS);
    cmd.term_sub   = (stage == STG_COS) && k[0];
    state_next     = state;
    k_next         = k;
    stage_next     = stage;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_X_MUL;
        end
      end
      S_X_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = epo_pkg::MUL_X;
        state_next  = S_LD_X;
      end
      S_LD_X: begin
        cmd.arg_ld      = 1'b1;
        cmd.arg_src     = epo_pkg::ARG_SHR12;
        cmd.series_init = 1'b1;
        k_next          = 5'd1;
        stage_next      = STG_MANT;
        state_next      = S_SER_MUL;
      end
      S_SER_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = epo_pkg::MUL_TERM;
        state_next  = S_SER_DLD;
      end
      S_SER_DLD: begin
        cmd.div_start = 1'b1;
        state_next    = S_SER_DIV;
      end
      S_SER_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_SER_ACC;
        end
      end
      S_SER_ACC: begin
        cmd.term_acc = 1'b1;
        k_next       = k + 5'd1;
        if (k != n_terms) begin
          state_next = S_SER_MUL;
        end else begin
          case (stage)
            STG_MANT:  state_next = S_INC_MUL;
            STG_PHASE: state_next = S_LD_D;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_INC_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = epo_pkg::MUL_INC;
        state_next  = S_INC_ADD;
      end
      S_INC_ADD: begin
        cmd.phase_ld = 1'b1;
        state_next   = S_PH_MUL;
      end
      S_PH_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = epo_pkg::MUL_PH;
        state_next  = S_LD_A;
      end
      S_LD_A: begin
        cmd.arg_ld      = 1'b1;
        cmd.arg_src     = epo_pkg::ARG_SHR30;
        cmd.series_init = 1'b1;
        k_next          = 5'd1;
        stage_next      = STG_PHASE;
        state_next      = S_SER_MUL;
      end
      S_LD_D: begin
        cmd.ad_ld  = 1'b1;
        state_next = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = epo_pkg::MUL_SQ;
        state_next  = S_LD_D2;
      end
      S_LD_D2: begin
        cmd.arg_ld      = 1'b1;
        cmd.arg_src     = epo_pkg::ARG_SHR30;
        cmd.series_init = 1'b1;
        k_next          = 5'd1;
        stage_next      = STG_COS;
        state_next      = S_SER_MUL;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      stage     <= STG_MANT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      stage <= stage_next;
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_X_MUL))
    else $error("transaction accepted without starting the pitch step");

  a_div_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> ($past(cmd.div_start) || $past(cmd.div_step)))
    else $error("divider stepped without a load");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> (!out_valid || out_ready))
    else $error("result overwrote a pending transaction");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SER_DIV) |-> (k >= 5'd1 && k <= epo_pkg::PHASE_TERMS))
    else $error("series term index out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/exp_pitch_phase_oscillator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake             | Payload
// ---------+-----------------------+----------------------------------------
// input    | in_valid / in_ready   | pitch_cv (17b signed, 1/4096 V)
// output   | out_valid / out_ready | wave_sample (16b signed, 1/4096 V)
// config   | cfg_write             | cfg_index, cfg_data (no wait)
//
// The result is registered in the output register at the end of each transaction:
// 36 series terms through one shared 34x32 multiplier and a 4-bit-per-cycle
// divider, plus setup and handshake steps.
// Synchronous active-high rst clears phase, knob and control; presets the C4 step.
// A finished result is held in the output register; the next input is taken
// meanwhile, and the block stalls at its end only if that result is unread.

module exp_pitch_phase_oscillator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [epo_pkg::CV_W-1:0]     pitch_cv,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [epo_pkg::WAVE_W-1:0]   wave_sample,
  input  logic                                cfg_write,
  input  logic [epo_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [epo_pkg::CFG_DATA_W-1:0]      cfg_data
);

  epo_pkg::cmd_t cmd;
  epo_pkg::sts_t sts;

  epo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  epo_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pitch_cv    (pitch_cv),
    .cmd         (cmd),
    .sts         (sts),
    .wave_sample (wave_sample)
  );

endmodule

`default_nettype wire
